// ----- design/sis_pkg.sv -----
// Shared types, constants and helpers for the sorted integer set.
// Depends on nothing; every other file of the block imports it.
package sis_pkg;

    localparam int CAPACITY = 16;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int EXT_W    = (CNT_W > 5) ? CNT_W : 5;

    localparam logic [31:0] SIGN_FLIP = 32'h8000_0000;

    typedef logic [1:0]        t_kind;
    typedef logic [1:0]        t_status;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [31:0]       t_key;

    localparam t_kind KIND_INSERT = 2'd0;
    localparam t_kind KIND_REMOVE = 2'd1;
    localparam t_kind KIND_QUERY  = 2'd2;

    localparam t_status STAT_DONE    = 2'd0;
    localparam t_status STAT_PRESENT = 2'd1;
    localparam t_status STAT_ABSENT  = 2'd2;
    localparam t_status STAT_FULL    = 2'd3;

    // One access to the element store: a read address every cycle, an optional write.
    typedef struct packed {
        t_addr raddr;
        logic  we;
        t_addr waddr;
        t_key  wdata;
    } t_mem_req;

    // The count port carries the low five bits of the number held.
    function automatic logic [4:0] to_count(input t_cnt held);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(held);
        return ext[4:0];
    endfunction

endpackage

// ----- design/sis_ram.sv -----
// Element store of the sorted integer set: one write port, one read port,
// read data registered. Depends on sis_pkg.
module sis_ram (
    input  logic              i_clk,
    input  sis_pkg::t_mem_req i_req,
    output sis_pkg::t_key     o_rdata
);
    import sis_pkg::*;

    t_key r_mem [CAPACITY];
    t_key r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/sis_ctrl.sv -----
// Sequencer of the sorted integer set: linear search, then, for insert or remove,
// a shift of cells up or down through the element store. Depends on sis_pkg.
module sis_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  sis_pkg::t_kind    i_kind,
    input  logic signed [31:0] i_value,
    output logic              busy,
    output logic              o_valid,
    output sis_pkg::t_status  o_status,
    output logic              o_found,
    output logic [4:0]        o_count,
    output sis_pkg::t_mem_req o_req,
    input  sis_pkg::t_key     i_rdata
);
    import sis_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SCAN = 6'b000010,
        ST_DEC  = 6'b000100,
        ST_UP   = 6'b001000,
        ST_PUT  = 6'b010000,
        ST_DN   = 6'b100000
    } t_state;

    t_state     r_state, n_state;
    t_cnt       r_held, n_held;
    t_cnt       r_pos, n_pos;
    t_cnt       r_idx, n_idx;
    logic       r_present, n_present;
    t_kind      r_kind, n_kind;
    t_key       r_key, n_key;
    t_status    r_status, n_status;
    logic       r_valid, n_valid;
    t_status    r_out_status, n_out_status;
    logic       r_out_found, n_out_found;
    logic [4:0] r_out_count, n_out_count;
    t_cnt       pos_inc, idx_dec, idx_inc, idx_inc2;

    // Address of the cell just below a count-wide index.
    function automatic t_addr idx_dec_of(input t_cnt idx);
        t_cnt d;
        d = idx - CNT_W'(1);
        return d[ADDR_W-1:0];
    endfunction

    assign pos_inc  = r_pos + CNT_W'(1);
    assign idx_dec  = r_idx - CNT_W'(1);
    assign idx_inc  = r_idx + CNT_W'(1);
    assign idx_inc2 = r_idx + CNT_W'(2);

    always_comb begin
        n_state      = r_state;
        n_held       = r_held;
        n_pos        = r_pos;
        n_idx        = r_idx;
        n_present    = r_present;
        n_kind       = r_kind;
        n_key        = r_key;
        n_status     = r_status;
        n_valid      = 1'b0;
        n_out_status = r_out_status;
        n_out_found  = r_out_found;
        n_out_count  = r_out_count;
        o_req        = '0;

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_kind    = i_kind;
                    n_key     = t_key'(i_value) ^ SIGN_FLIP;
                    n_pos     = '0;
                    n_present = 1'b0;
                    n_state   = (r_held == '0) ? ST_DEC : ST_SCAN;
                end
            end
            ST_SCAN: begin
                // The read for the next cell goes out while this one is compared.
                if (i_rdata < r_key) begin
                    n_pos = pos_inc;
                    if (pos_inc == r_held) begin
                        n_state = ST_DEC;
                    end else begin
                        o_req.raddr = pos_inc[ADDR_W-1:0];
                    end
                end else begin
                    n_present = (i_rdata == r_key);
                    n_state   = ST_DEC;
                end
            end
            ST_DEC: begin
                n_out_found = r_present;
                case (r_kind)
                    KIND_INSERT: begin
                        if (r_present) begin
                            n_out_status = STAT_PRESENT;
                            n_out_count  = to_count(r_held);
                            n_valid      = 1'b1;
                            n_state      = ST_IDLE;
                        end else if (r_held == CNT_W'(CAPACITY)) begin
                            n_out_status = STAT_FULL;
                            n_out_count  = to_count(r_held);
                            n_valid      = 1'b1;
                            n_state      = ST_IDLE;
                        end else if (r_held == r_pos) begin
                            n_status = STAT_DONE;
                            n_state  = ST_PUT;
                        end else begin
                            n_status    = STAT_DONE;
                            n_idx       = r_held;
                            o_req.raddr = idx_dec_of(r_held);
                            n_state     = ST_UP;
                        end
                    end
                    KIND_REMOVE: begin
                        if (!r_present) begin
                            n_out_status = STAT_ABSENT;
                            n_out_count  = to_count(r_held);
                            n_valid      = 1'b1;
                            n_state      = ST_IDLE;
                        end else if (pos_inc == r_held) begin
                            n_held       = r_held - CNT_W'(1);
                            n_out_status = STAT_DONE;
                            n_out_count  = to_count(n_held);
                            n_valid      = 1'b1;
                            n_state      = ST_IDLE;
                        end else begin
                            n_status    = STAT_DONE;
                            n_idx       = r_pos;
                            o_req.raddr = pos_inc[ADDR_W-1:0];
                            n_state     = ST_DN;
                        end
                    end
                    default: begin
                        n_out_status = r_present ? STAT_DONE : STAT_ABSENT;
                        n_out_count  = to_count(r_held);
                        n_valid      = 1'b1;
                        n_state      = ST_IDLE;
                    end
                endcase
            end
            ST_UP: begin
                // Cell idx-1 has arrived; it moves up into cell idx.
                o_req.we    = 1'b1;
                o_req.waddr = r_idx[ADDR_W-1:0];
                o_req.wdata = i_rdata;
                n_idx       = idx_dec;
                if (idx_dec == r_pos) begin
                    n_state = ST_PUT;
                end else begin
                    o_req.raddr = idx_dec_of(idx_dec);
                end
            end
            ST_PUT: begin
                o_req.we     = 1'b1;
                o_req.waddr  = r_pos[ADDR_W-1:0];
                o_req.wdata  = r_key;
                n_held       = r_held + CNT_W'(1);
                n_out_status = r_status;
                n_out_count  = to_count(n_held);
                n_valid      = 1'b1;
                n_state      = ST_IDLE;
            end
            ST_DN: begin
                // Cell idx+1 has arrived; it moves down into cell idx.
                o_req.we    = 1'b1;
                o_req.waddr = r_idx[ADDR_W-1:0];
                o_req.wdata = i_rdata;
                n_idx       = idx_inc;
                if (idx_inc2 == r_held) begin
                    n_held       = r_held - CNT_W'(1);
                    n_out_status = r_status;
                    n_out_count  = to_count(n_held);
                    n_valid      = 1'b1;
                    n_state      = ST_IDLE;
                end else begin
                    o_req.raddr = idx_inc2[ADDR_W-1:0];
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_held  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_held  <= n_held;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_idx        <= n_idx;
        r_present    <= n_present;
        r_kind       <= n_kind;
        r_key        <= n_key;
        r_status     <= n_status;
        r_out_status <= n_out_status;
        r_out_found  <= n_out_found;
        r_out_count  <= n_out_count;
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_valid  = r_valid;
    assign o_status = r_out_status;
    assign o_found  = r_out_found;
    assign o_count  = r_out_count;

    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    a_no_write_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE || r_state == ST_SCAN || r_state == ST_DEC) |-> !o_req.we)
        else $error("store written before the search settled");

    a_held_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held != $past(r_held)) |->
            (r_held == $past(r_held) + CNT_W'(1) || r_held == $past(r_held) - CNT_W'(1)))
        else $error("element count moved by more than one");

    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == ST_IDLE && $past(r_state) != ST_IDLE))
        else $error("result beat without a request in flight");

    a_start_gets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not make the block busy");

endmodule

// ----- design/sorted_integer_set.sv -----
// Sorted integer set, top level: element store plus search/shift sequencer.
// Order of work after start is taken: the cells are compared in turn (up to the count),
// the outcome is decided, cells are moved (and the key is put in on insert), then the beat.
// Throughput: one request at a time; busy is high until the result beat, and a new
// start is taken in the cycle the beat is shown. The receiver cannot stall the beat.
// Reset (synchronous, active low) empties the set; store contents need no clearing.
module sorted_integer_set (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  sis_pkg::t_kind     i_kind,
    input  logic signed [31:0] i_value,
    output logic               busy,
    output logic               o_valid,
    output sis_pkg::t_status   o_status,
    output logic               o_found,
    output logic [4:0]         o_count
);
    import sis_pkg::*;

    t_mem_req mem_req;
    t_key     mem_rdata;

    sis_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_kind   (i_kind),
        .i_value  (i_value),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_status (o_status),
        .o_found  (o_found),
        .o_count  (o_count),
        .o_req    (mem_req),
        .i_rdata  (mem_rdata)
    );

    sis_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

endmodule
